@@ rtl/char_to_glyph_segment_lookup_assert.svh @@
// Assertion helpers shared by the lookup RTL.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef CHAR_TO_GLYPH_SEGMENT_LOOKUP_ASSERT_SVH
`define CHAR_TO_GLYPH_SEGMENT_LOOKUP_ASSERT_SVH

// Same-cycle implication
`define C2G_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define C2G_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/c2g_pkg.sv @@
package c2g_pkg;

  // Field widths of the transaction payloads
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned CHAR_W   = 21;
  localparam int unsigned GLYPH_W  = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 9;

  // Item modes
  typedef enum logic [MODE_W-1:0] {
    MODE_SEG_WR   = 2'd0,
    MODE_GLYPH_WR = 2'd1,
    MODE_LOOKUP   = 2'd2
  } mode_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_MISS  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  // One segment table entry
  typedef struct packed {
    logic [CODE_W-1:0] end_code;
    logic [CODE_W-1:0] start_code;
    logic [CODE_W-1:0] id_delta;
    logic [CODE_W-1:0] range_offset;
  } seg_t;

  localparam int unsigned SEG_W = $bits(seg_t);

endpackage

@@ rtl/c2g_in_if.sv @@
interface c2g_in_if;
  import c2g_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [IDX_W-1:0]         entry_index;
  logic [CODE_W-1:0]        end_code;
  logic [CODE_W-1:0]        start_code;
  logic signed [CODE_W-1:0] id_delta;
  logic [CODE_W-1:0]        range_offset;
  logic [GLYPH_W-1:0]       glyph_word;
  logic [CHAR_W-1:0]        char_code;

  modport source (
    output valid, mode, entry_index, end_code, start_code, id_delta, range_offset,
           glyph_word, char_code,
    input  ready
  );

  modport sink (
    input  valid, mode, entry_index, end_code, start_code, id_delta, range_offset,
           glyph_word, char_code,
    output ready
  );
endinterface

@@ rtl/c2g_out_if.sv @@
interface c2g_out_if;
  import c2g_pkg::*;

  logic                valid;
  logic                ready;
  logic [GLYPH_W-1:0]  glyph_index;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, glyph_index, status,
    input  ready
  );

  modport sink (
    input  valid, glyph_index, status,
    output ready
  );
endinterface

@@ rtl/c2g_ram.sv @@
module c2g_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold data while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/char_to_glyph_segment_lookup.sv @@
// Character code to glyph index lookup over a segment-mapped table.
// Input channel item_i (valid/ready) carries three kinds of transaction:
// segment write, glyph-array word write and character lookup. Writes return
// nothing; each lookup returns one transaction on result_o with
// glyph_index and status. segment_count is written through
// segment_count_we_i / segment_count_i; the user must write it only while
// the block is idle, and the block itself does not enforce this.
// A lookup is a binary search over the segment RAM, one read per probe and
// a second read of the neighbor entry when the probed end code covers the
// code and the probe is not entry 0. The S_FOUND state then checks the hit
// segment, and one glyph RAM read follows if the range offset is nonzero
// and the glyph index lies inside the array. The output register loads
// from S_FOUND, S_GLYPH or S_MISS once the output is free. The input is
// ready again as soon as the result loads. One lookup is in flight at a
// time; the input stays ready while a finished result waits on a stalled
// receiver, but the next lookup holds its result until the output frees.
// Reset sets segment_count to 1 and empties the output register; the RAM
// contents are undefined until written, with no clearing pass.
module char_to_glyph_segment_lookup #(
  parameter int unsigned MAX_SEGMENTS = 256,
  parameter int unsigned GLYPH_WORDS  = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      segment_count_we_i,
  input  logic [c2g_pkg::CFG_W-1:0] segment_count_i,
  c2g_in_if.sink                    item_i,
  c2g_out_if.source                 result_o
);
  import c2g_pkg::*;

  localparam int unsigned CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SEG_AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned GW_AW   = (GLYPH_WORDS > 1) ? $clog2(GLYPH_WORDS) : 1;
  localparam int unsigned CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned SWR_W   = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int unsigned GWN_W   = $clog2(GLYPH_WORDS + 1);
  localparam int unsigned GWR_W   = (IDX_W > GWN_W) ? IDX_W : GWN_W;
  localparam int unsigned GIX_W   = 18;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_PREV,
    S_FOUND,
    S_GLYPH,
    S_MISS
  } state_e;

  state_e               state_q, state_d;
  logic [CFG_W-1:0]     segment_count_q;
  logic [CNT_W-1:0]     left_q, left_d;
  logic [CNT_W-1:0]     r1_q, r1_d;
  logic [SEG_AW-1:0]    mid_q, mid_d;
  logic [CODE_W-1:0]    code_q, code_d;
  seg_t                 seg_q, seg_d;
  logic                 out_valid_q, out_valid_d;
  logic [GLYPH_W-1:0]   glyph_q, glyph_d;
  status_e              status_q, status_d;

  logic                 in_accept;
  logic                 out_free;
  logic [CMP_W-1:0]     cnt_ext;
  logic [CNT_W-1:0]     cnt;
  logic [SWR_W-1:0]     seg_widx;
  logic [GWR_W-1:0]     glyph_widx;
  logic                 seg_we, glyph_we;
  logic                 seg_re, glyph_re;
  logic [SEG_AW-1:0]    seg_raddr;
  logic [SEG_W-1:0]     seg_rdata;
  seg_t                 seg_rd;
  logic [GLYPH_W-1:0]   glyph_rdata;
  logic [GIX_W-1:0]     gix;
  logic                 gix_ok;
  logic                 lookup_go;
  logic                 in_search;
  logic                 mid_in_window;
  logic                 in_result_state;
  logic                 fail_out;

  function automatic logic [SEG_AW-1:0] next_mid(input logic [CNT_W-1:0] l,
                                                 input logic [CNT_W-1:0] r);
    logic [CNT_W:0] s;
    s = {1'b0, l} + {1'b0, r} - (CNT_W + 1)'(1);
    return s[SEG_AW:1];
  endfunction

  // Handshakes
  assign item_i.ready = (state_q == S_IDLE);
  assign in_accept    = item_i.valid && item_i.ready;
  assign out_free     = !out_valid_q || result_o.ready;

  // Saturate the segment count to the table depth
  assign cnt_ext = CMP_W'(segment_count_q);
  assign cnt     = (cnt_ext > CMP_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
                                                    : CNT_W'(cnt_ext);

  // Table writes, dropped when the index lies beyond the store
  assign seg_widx   = SWR_W'(item_i.entry_index);
  assign glyph_widx = GWR_W'(item_i.entry_index);
  assign seg_we     = in_accept && (item_i.mode == MODE_SEG_WR)
                      && (seg_widx < SWR_W'(MAX_SEGMENTS));
  assign glyph_we   = in_accept && (item_i.mode == MODE_GLYPH_WR)
                      && (glyph_widx < GWR_W'(GLYPH_WORDS));

  assign seg_rd = seg_t'(seg_rdata);

  // Glyph-array word index of the hit segment, two's complement
  assign gix    = GIX_W'(seg_q.range_offset[CODE_W-1:1])
                + GIX_W'(code_q - seg_q.start_code)
                - GIX_W'(cnt) + GIX_W'(mid_q);
  assign gix_ok = !gix[GIX_W-1] && (gix < GIX_W'(GLYPH_WORDS));

  // Search sequencer
  always_comb begin
    state_d     = state_q;
    left_d      = left_q;
    r1_d        = r1_q;
    mid_d       = mid_q;
    code_d      = code_q;
    seg_d       = seg_q;
    out_valid_d = out_valid_q && !result_o.ready;
    glyph_d     = glyph_q;
    status_d    = status_q;
    seg_re      = 1'b0;
    seg_raddr   = mid_q;
    glyph_re    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept && (item_i.mode == MODE_LOOKUP)) begin
          code_d = item_i.char_code[CODE_W-1:0];
          if ((item_i.char_code[CHAR_W-1:CODE_W] != '0) || (cnt == '0)) begin
            state_d = S_MISS;
          end else begin
            left_d    = '0;
            r1_d      = cnt;
            mid_d     = next_mid('0, cnt);
            seg_re    = 1'b1;
            seg_raddr = mid_d;
            state_d   = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (seg_rd.end_code >= code_q) begin
          seg_d = seg_rd;
          if (mid_q == '0) begin
            state_d = S_FOUND;
          end else begin
            seg_re    = 1'b1;
            seg_raddr = mid_q - SEG_AW'(1);
            state_d   = S_PREV;
          end
        end else begin
          left_d = CNT_W'(mid_q) + CNT_W'(1);
          if (left_d < r1_q) begin
            mid_d     = next_mid(left_d, r1_q);
            seg_re    = 1'b1;
            seg_raddr = mid_d;
          end else begin
            state_d = S_MISS;
          end
        end
      end
      S_PREV: begin
        if (seg_rd.end_code < code_q) begin
          state_d = S_FOUND;
        end else begin
          r1_d = CNT_W'(mid_q);
          if (left_q < r1_d) begin
            mid_d     = next_mid(left_q, r1_d);
            seg_re    = 1'b1;
            seg_raddr = mid_d;
            state_d   = S_PROBE;
          end else begin
            state_d = S_MISS;
          end
        end
      end
      S_FOUND: begin
        if (seg_q.start_code > code_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            glyph_d     = '0;
            status_d    = STATUS_MISS;
            state_d     = S_IDLE;
          end
        end else if (seg_q.range_offset == '0) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            glyph_d     = code_q + seg_q.id_delta;
            status_d    = STATUS_OK;
            state_d     = S_IDLE;
          end
        end else if (!gix_ok) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            glyph_d     = '0;
            status_d    = STATUS_RANGE;
            state_d     = S_IDLE;
          end
        end else begin
          glyph_re = 1'b1;
          state_d  = S_GLYPH;
        end
      end
      S_GLYPH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          glyph_d     = (glyph_rdata == '0) ? '0 : glyph_rdata + seg_q.id_delta;
          status_d    = STATUS_OK;
          state_d     = S_IDLE;
        end
      end
      S_MISS: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          glyph_d     = '0;
          status_d    = STATUS_MISS;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, search registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      segment_count_q <= CFG_W'(1);
      left_q          <= '0;
      r1_q            <= '0;
      mid_q           <= '0;
      code_q          <= '0;
      seg_q           <= '0;
      out_valid_q     <= 1'b0;
      glyph_q         <= '0;
      status_q        <= STATUS_OK;
    end else begin
      state_q     <= state_d;
      left_q      <= left_d;
      r1_q        <= r1_d;
      mid_q       <= mid_d;
      code_q      <= code_d;
      seg_q       <= seg_d;
      out_valid_q <= out_valid_d;
      glyph_q     <= glyph_d;
      status_q    <= status_d;
      if (segment_count_we_i) begin
        segment_count_q <= segment_count_i;
      end
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.glyph_index = glyph_q;
  assign result_o.status      = status_q;

  // Segment table
  c2g_ram #(
    .WIDTH (SEG_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (seg_widx[SEG_AW-1:0]),
    .wdata_i ({item_i.end_code, item_i.start_code, item_i.id_delta, item_i.range_offset}),
    .re_i    (seg_re),
    .raddr_i (seg_raddr),
    .rdata_o (seg_rdata)
  );

  // Glyph array
  c2g_ram #(
    .WIDTH (GLYPH_W),
    .DEPTH (GLYPH_WORDS)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (glyph_we),
    .waddr_i (glyph_widx[GW_AW-1:0]),
    .wdata_i (item_i.glyph_word),
    .re_i    (glyph_re),
    .raddr_i (gix[GW_AW-1:0]),
    .rdata_o (glyph_rdata)
  );

  // Conditions watched by the checks below
  assign lookup_go       = in_accept && (item_i.mode == MODE_LOOKUP);
  assign in_search       = (state_q == S_PROBE) || (state_q == S_PREV);
  assign mid_in_window   = (left_q < r1_q) && (CNT_W'(mid_q) >= left_q)
                           && (CNT_W'(mid_q) < r1_q);
  assign in_result_state = (state_q == S_FOUND) || (state_q == S_GLYPH)
                           || (state_q == S_MISS);
  assign fail_out        = out_valid_q && (status_q != STATUS_OK);

  `include "char_to_glyph_segment_lookup_assert.svh"

  `C2G_ASSERT_NEXT(a_lookup_leaves_idle, lookup_go, state_q != S_IDLE, "lookup stayed idle")
  `C2G_ASSERT_IMPL(a_search_window, in_search, mid_in_window, "probe outside search window")
  `C2G_ASSERT_IMPL(a_prev_nonzero, state_q == S_PREV, mid_q != '0, "neighbor read below zero")
  `C2G_ASSERT_IMPL(a_result_source, $rose(out_valid_q), $past(in_result_state), "stray result")
  `C2G_ASSERT_IMPL(a_fail_zero_glyph, fail_out, glyph_q == '0, "failed lookup has nonzero glyph")

endmodule
